[hw/rtl/dq_pkg.sv]
// Shared types, constants and index helpers for the double-ended queue.
// Used by double_ended_queue; depends on nothing.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DISPLAY    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_DISPLAY = 1'b1
  } state_e;

  // Slot that lies off entries past base, wrapped round the storage.
  // base < DEPTH and off <= DEPTH, so one conditional subtract is enough.
  function automatic logic [IDX_W-1:0] wrap_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Slot in front of base, wrapped round the storage.
  function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

[hw/rtl/dq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/double_ended_queue.sv]
// Double-ended queue top level: command decode, pointers and output stage.
// Depends on dq_pkg and on dq_ram for the entry storage.
//
//   port group   dir  tdata            tuser          tlast
//   s_axis       in   value[31:0]      command[2:0]   -
//   m_axis       out  data[31:0]       status[1:0]    last
//
// A pop issues the read in the accept cycle, and the output shows the RAM
// read register directly. A display streams one entry per cycle while the
// output is not stalled, set by the single RAM read port; no new command is
// taken until the cycle after its last word leaves.
// Reset clears head, fill count, state and output valid; entries are not
// cleared and stay undefined until pushed. A stalled output holds its word,
// and no command is taken until that word is taken or leaves this cycle.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] data
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o
);

  // Pointer and control state
  dq_pkg::state_e               state_q, state_d;
  logic [dq_pkg::IDX_W-1:0]     head_q, head_d;
  logic [dq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [dq_pkg::CNT_W-1:0]     disp_off_q, disp_off_d;

  // Output stage: status comes from a register, data from the RAM read
  // register when the word carries an entry, zero otherwise.
  logic                         out_valid_q, out_valid_d;
  logic                         out_ram_q, out_ram_d;
  dq_pkg::status_e              out_status_q, out_status_d;

  // RAM port controls
  logic                         ram_we, ram_re;
  logic [dq_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [dq_pkg::DATA_W-1:0]    ram_rdata;

  logic in_fire, out_fire, out_free, q_full, q_empty, disp_last;

  assign q_full    = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign q_empty   = (count_q == '0);
  assign out_fire  = out_valid_q & m_axis_tready_i;
  assign out_free  = ~out_valid_q | m_axis_tready_i;
  assign disp_last = ((disp_off_q + dq_pkg::CNT_W'(1)) == count_q);

  assign s_axis_tready_o = (state_q == dq_pkg::S_IDLE) & out_free;
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_ram_q ? ram_rdata : '0;
  assign m_axis_tuser_o  = out_status_q;
  // each known command has one word, except display whose final word alone ends it
  assign m_axis_tlast_o  = (state_q == dq_pkg::S_DISPLAY) ? disp_last : 1'b1;

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    disp_off_d   = disp_off_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_ram_d    = out_ram_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = head_q;
    ram_re       = 1'b0;
    ram_raddr    = head_q;

    unique case (state_q)
      dq_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (dq_pkg::cmd_e'(s_axis_tuser_i))
            dq_pkg::CMD_PUSH_FRONT: begin
              out_valid_d = 1'b1;
              out_ram_d   = 1'b0;
              if (q_full) begin
                out_status_d = dq_pkg::STAT_FULL;
              end else begin
                // step head back and store in front of the old head
                ram_we       = 1'b1;
                ram_waddr    = dq_pkg::prev_slot(head_q);
                head_d       = dq_pkg::prev_slot(head_q);
                count_d      = count_q + dq_pkg::CNT_W'(1);
                out_status_d = dq_pkg::STAT_OK;
              end
            end
            dq_pkg::CMD_PUSH_BACK: begin
              out_valid_d = 1'b1;
              out_ram_d   = 1'b0;
              if (q_full) begin
                out_status_d = dq_pkg::STAT_FULL;
              end else begin
                ram_we       = 1'b1;
                ram_waddr    = dq_pkg::wrap_slot(head_q, count_q);
                count_d      = count_q + dq_pkg::CNT_W'(1);
                out_status_d = dq_pkg::STAT_OK;
              end
            end
            dq_pkg::CMD_POP_FRONT: begin
              out_valid_d = 1'b1;
              if (q_empty) begin
                out_ram_d    = 1'b0;
                out_status_d = dq_pkg::STAT_EMPTY;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = head_q;
                head_d       = dq_pkg::wrap_slot(head_q, dq_pkg::CNT_W'(1));
                count_d      = count_q - dq_pkg::CNT_W'(1);
                out_ram_d    = 1'b1;
                out_status_d = dq_pkg::STAT_OK;
              end
            end
            dq_pkg::CMD_POP_BACK: begin
              out_valid_d = 1'b1;
              if (q_empty) begin
                out_ram_d    = 1'b0;
                out_status_d = dq_pkg::STAT_EMPTY;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = dq_pkg::wrap_slot(head_q, count_q - dq_pkg::CNT_W'(1));
                count_d      = count_q - dq_pkg::CNT_W'(1);
                out_ram_d    = 1'b1;
                out_status_d = dq_pkg::STAT_OK;
              end
            end
            dq_pkg::CMD_DISPLAY: begin
              out_valid_d = 1'b1;
              if (q_empty) begin
                out_ram_d    = 1'b0;
                out_status_d = dq_pkg::STAT_EMPTY;
              end else begin
                // read the front entry and walk toward the back
                ram_re       = 1'b1;
                ram_raddr    = head_q;
                disp_off_d   = '0;
                out_ram_d    = 1'b1;
                out_status_d = dq_pkg::STAT_OK;
                state_d      = dq_pkg::S_DISPLAY;
              end
            end
            default: begin
              // unknown command: drop it, no word out
            end
          endcase
        end
      end
      dq_pkg::S_DISPLAY: begin
        if (out_fire) begin
          if (disp_last) begin
            state_d = dq_pkg::S_IDLE;
          end else begin
            // advance to the next entry; RAM data holds while stalled
            ram_re      = 1'b1;
            ram_raddr   = dq_pkg::wrap_slot(head_q, disp_off_q + dq_pkg::CNT_W'(1));
            disp_off_d  = disp_off_q + dq_pkg::CNT_W'(1);
            out_valid_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dq_pkg::S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      disp_off_q   <= '0;
      out_valid_q  <= 1'b0;
      out_ram_q    <= 1'b0;
      out_status_q <= dq_pkg::STAT_OK;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      disp_off_q   <= disp_off_d;
      out_valid_q  <= out_valid_d;
      out_ram_q    <= out_ram_d;
      out_status_q <= out_status_d;
    end
  end

  // Fill count never passes the storage size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
    else $error("fill count exceeds depth");

  // No command is taken while a display is streaming.
  a_no_accept_in_display: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dq_pkg::S_DISPLAY) |-> !s_axis_tready_o)
    else $error("command accepted during display");

  // A push-back that is not refused grows the queue by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser_i == dq_pkg::CMD_PUSH_BACK) && !q_full)
    |=> (count_q == $past(count_q) + dq_pkg::CNT_W'(1)))
    else $error("push back did not grow the queue");

  // A word that carries a stored entry always reports OK.
  a_ram_word_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ram_q) |-> (out_status_q == dq_pkg::STAT_OK))
    else $error("entry word with refusal status");

endmodule
